FILE: sv/hrck_pkg.sv
// Shared types and constants for the HSV/RGB color key unit.
// Used by hrck_regs, hrck_prep and the top level; depends on nothing.
package hrck_pkg;

  localparam int PIX_W      = 8;
  localparam int HUE_W      = 15;
  localparam int SAT_W      = 13;
  localparam int T_W        = 11;  // sector-scaled hue numerator, up to 6*255
  localparam int HUE_NUM_W  = 23;  // T_W term times one sector of hue
  localparam int SAT_SHIFT  = 12;  // saturation scale, 4096
  localparam int SAT_NUM_W  = PIX_W + SAT_SHIFT;
  localparam int CHAN_W     = 3 * PIX_W;
  localparam int ADDR_W     = 5;
  localparam int DATA_W     = 32;
  localparam int DIV_STAGES = 4;
  localparam int LATENCY    = 3 + DIV_STAGES;  // start to result strobe

  localparam logic [HUE_NUM_W-1:0] HUE_SECTOR = HUE_NUM_W'(3840);

  localparam logic [HUE_W-1:0]  HUE_HIGH_RST  = HUE_W'(23040);
  localparam logic [SAT_W-1:0]  SAT_HIGH_RST  = SAT_W'(4096);
  localparam logic [PIX_W-1:0]  VAL_HIGH_RST  = PIX_W'(255);
  localparam logic [CHAN_W-1:0] CHAN_HIGH_RST = CHAN_W'(24'hFFFFFF);
  localparam logic [SAT_W-1:0]  SAT_MAX       = SAT_W'(4096);
  localparam logic [HUE_W-1:0]  HUE_LIMIT     = HUE_W'(23040);

  typedef enum logic [2:0] {
    REG_HUE_LOW   = 3'd0,
    REG_HUE_HIGH  = 3'd1,
    REG_SAT_LOW   = 3'd2,
    REG_SAT_HIGH  = 3'd3,
    REG_VAL_LOW   = 3'd4,
    REG_VAL_HIGH  = 3'd5,
    REG_CHAN_LOW  = 3'd6,
    REG_CHAN_HIGH = 3'd7
  } reg_idx_t;

  typedef enum logic [1:0] {
    SEC_RED_POS = 2'd0,
    SEC_RED_NEG = 2'd1,
    SEC_GREEN   = 2'd2,
    SEC_BLUE    = 2'd3
  } sector_t;

  typedef struct packed {
    logic [PIX_W-1:0] pix_red;
    logic [PIX_W-1:0] pix_green;
    logic [PIX_W-1:0] pix_blue;
  } pix_t;

  typedef struct packed {
    logic [PIX_W-1:0] hsv_out_red;
    logic [PIX_W-1:0] hsv_out_green;
    logic [PIX_W-1:0] hsv_out_blue;
    logic [PIX_W-1:0] rgb_out_red;
    logic [PIX_W-1:0] rgb_out_green;
    logic [PIX_W-1:0] rgb_out_blue;
    logic [HUE_W-1:0] hue_val;
    logic [SAT_W-1:0] sat_val;
    logic [PIX_W-1:0] bright_val;
    logic             hsv_hit;
    logic             rgb_hit;
  } res_t;

  typedef struct packed {
    logic [HUE_W-1:0]  hue_low;
    logic [HUE_W-1:0]  hue_high;
    logic [SAT_W-1:0]  sat_low;
    logic [SAT_W-1:0]  sat_high;
    logic [PIX_W-1:0]  val_low;
    logic [PIX_W-1:0]  val_high;
    logic [CHAN_W-1:0] chan_low;
    logic [CHAN_W-1:0] chan_high;
  } cfg_t;

  typedef struct packed {
    logic                 valid;
    pix_t                 pix;
    logic [PIX_W-1:0]     mx;
    logic [HUE_NUM_W-1:0] num_hue;
    logic [PIX_W-1:0]     den_hue;
    logic [SAT_NUM_W-1:0] num_sat;
    logic [PIX_W-1:0]     den_sat;
  } prep_t;

endpackage

FILE: sv/hrck_regs.sv
// APB configuration registers for the color key thresholds.
// Depends on hrck_pkg.
module hrck_regs (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [hrck_pkg::ADDR_W-1:0] paddr,
  input  logic [hrck_pkg::DATA_W-1:0] pwdata,
  output logic [hrck_pkg::DATA_W-1:0] prdata,
  output logic                       pready,
  output hrck_pkg::cfg_t             cfg
);

  hrck_pkg::reg_idx_t idx;
  logic               wr_en;

  assign idx    = hrck_pkg::reg_idx_t'(paddr[hrck_pkg::ADDR_W-1:2]);
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.hue_low   <= '0;
      cfg.hue_high  <= hrck_pkg::HUE_HIGH_RST;
      cfg.sat_low   <= '0;
      cfg.sat_high  <= hrck_pkg::SAT_HIGH_RST;
      cfg.val_low   <= '0;
      cfg.val_high  <= hrck_pkg::VAL_HIGH_RST;
      cfg.chan_low  <= '0;
      cfg.chan_high <= hrck_pkg::CHAN_HIGH_RST;
    end else if (wr_en) begin
      unique case (idx)
        hrck_pkg::REG_HUE_LOW:   cfg.hue_low   <= pwdata[hrck_pkg::HUE_W-1:0];
        hrck_pkg::REG_HUE_HIGH:  cfg.hue_high  <= pwdata[hrck_pkg::HUE_W-1:0];
        hrck_pkg::REG_SAT_LOW:   cfg.sat_low   <= pwdata[hrck_pkg::SAT_W-1:0];
        hrck_pkg::REG_SAT_HIGH:  cfg.sat_high  <= pwdata[hrck_pkg::SAT_W-1:0];
        hrck_pkg::REG_VAL_LOW:   cfg.val_low   <= pwdata[hrck_pkg::PIX_W-1:0];
        hrck_pkg::REG_VAL_HIGH:  cfg.val_high  <= pwdata[hrck_pkg::PIX_W-1:0];
        hrck_pkg::REG_CHAN_LOW:  cfg.chan_low  <= pwdata[hrck_pkg::CHAN_W-1:0];
        hrck_pkg::REG_CHAN_HIGH: cfg.chan_high <= pwdata[hrck_pkg::CHAN_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      hrck_pkg::REG_HUE_LOW:   prdata = hrck_pkg::DATA_W'(cfg.hue_low);
      hrck_pkg::REG_HUE_HIGH:  prdata = hrck_pkg::DATA_W'(cfg.hue_high);
      hrck_pkg::REG_SAT_LOW:   prdata = hrck_pkg::DATA_W'(cfg.sat_low);
      hrck_pkg::REG_SAT_HIGH:  prdata = hrck_pkg::DATA_W'(cfg.sat_high);
      hrck_pkg::REG_VAL_LOW:   prdata = hrck_pkg::DATA_W'(cfg.val_low);
      hrck_pkg::REG_VAL_HIGH:  prdata = hrck_pkg::DATA_W'(cfg.val_high);
      hrck_pkg::REG_CHAN_LOW:  prdata = hrck_pkg::DATA_W'(cfg.chan_low);
      hrck_pkg::REG_CHAN_HIGH: prdata = hrck_pkg::DATA_W'(cfg.chan_high);
    endcase
  end

endmodule

FILE: sv/hrck_prep.sv
// Front end: max/min, hue sector and the divider operands, two register stages.
// Depends on hrck_pkg.
module hrck_prep (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  hrck_pkg::pix_t  pix,
  output hrck_pkg::prep_t prep
);

  // stage 1
  logic                        s1_valid;
  hrck_pkg::pix_t              s1_pix;
  logic [hrck_pkg::PIX_W-1:0]  s1_mx;
  logic [hrck_pkg::PIX_W-1:0]  s1_mn;
  hrck_pkg::sector_t           s1_sec;

  logic [hrck_pkg::PIX_W-1:0]  mx_c;
  logic [hrck_pkg::PIX_W-1:0]  mn_c;
  hrck_pkg::sector_t           sec_c;

  // stage 2 operands
  logic [hrck_pkg::PIX_W-1:0]     d_c;
  logic [hrck_pkg::T_W-1:0]       t_c;
  logic [hrck_pkg::T_W-1:0]       r_t;
  logic [hrck_pkg::T_W-1:0]       g_t;
  logic [hrck_pkg::T_W-1:0]       b_t;
  logic [hrck_pkg::T_W-1:0]       d_t;
  logic [hrck_pkg::HUE_NUM_W-1:0] num_hue_c;

  always_comb begin
    mx_c = pix.pix_red;
    mn_c = pix.pix_red;
    if (pix.pix_green > mx_c) mx_c = pix.pix_green;
    if (pix.pix_blue > mx_c) mx_c = pix.pix_blue;
    if (pix.pix_green < mn_c) mn_c = pix.pix_green;
    if (pix.pix_blue < mn_c) mn_c = pix.pix_blue;
  end

  // ties: red wins over green, green over blue
  always_comb begin
    priority if (mx_c == pix.pix_red) begin
      sec_c = (pix.pix_green >= pix.pix_blue) ? hrck_pkg::SEC_RED_POS
                                              : hrck_pkg::SEC_RED_NEG;
    end else if (mx_c == pix.pix_green) begin
      sec_c = hrck_pkg::SEC_GREEN;
    end else begin
      sec_c = hrck_pkg::SEC_BLUE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= in_valid;
    end
    s1_pix <= pix;
    s1_mx  <= mx_c;
    s1_mn  <= mn_c;
    s1_sec <= sec_c;
  end

  assign d_c = s1_mx - s1_mn;
  assign r_t = hrck_pkg::T_W'(s1_pix.pix_red);
  assign g_t = hrck_pkg::T_W'(s1_pix.pix_green);
  assign b_t = hrck_pkg::T_W'(s1_pix.pix_blue);
  assign d_t = hrck_pkg::T_W'(d_c);

  // hue numerator in sector units, always in 0..6d
  always_comb begin
    unique case (s1_sec)
      hrck_pkg::SEC_RED_POS: t_c = g_t - b_t;
      hrck_pkg::SEC_RED_NEG: t_c = (d_t << 2) + (d_t << 1) - (b_t - g_t);
      hrck_pkg::SEC_GREEN:   t_c = (d_t << 1) + b_t - r_t;
      hrck_pkg::SEC_BLUE:    t_c = (d_t << 2) + r_t - g_t;
    endcase
  end

  assign num_hue_c = hrck_pkg::HUE_NUM_W'(t_c) * hrck_pkg::HUE_SECTOR;

  always_ff @(posedge clk) begin
    if (rst) begin
      prep.valid <= 1'b0;
    end else begin
      prep.valid <= s1_valid;
    end
    prep.pix     <= s1_pix;
    prep.mx      <= s1_mx;
    prep.num_hue <= num_hue_c;
    // grey or black pixel: numerator is zero, divide by one to get zero
    prep.den_hue <= (d_c == '0) ? hrck_pkg::PIX_W'(1) : d_c;
    prep.num_sat <= {d_c, hrck_pkg::SAT_SHIFT'(0)};
    prep.den_sat <= (s1_mx == '0) ? hrck_pkg::PIX_W'(1) : s1_mx;
  end

endmodule

FILE: sv/hrck_div.sv
// Pipelined restoring divider, up to BPS quotient bits per stage.
// Assumes num < den * 2**Q_W. Depends on nothing outside this file.
module hrck_div #(
  parameter int NUM_W  = 23,
  parameter int DEN_W  = 8,
  parameter int Q_W    = 15,
  parameter int STAGES = 4
) (
  input  logic             clk,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic [Q_W-1:0]   quo
);

  localparam int BPS = (Q_W + STAGES - 1) / STAGES;

  logic [DEN_W-1:0] rem_p [1:STAGES];
  logic [Q_W-1:0]   low_p [1:STAGES];
  logic [Q_W-1:0]   quo_p [1:STAGES];
  logic [DEN_W-1:0] den_p [1:STAGES];

  for (genvar s = 0; s < STAGES; s++) begin : g_stage
    logic [DEN_W-1:0] rem_i;
    logic [Q_W-1:0]   low_i;
    logic [Q_W-1:0]   quo_i;
    logic [DEN_W-1:0] den_i;
    logic [DEN_W-1:0] rem_n;
    logic [Q_W-1:0]   low_n;
    logic [Q_W-1:0]   quo_n;

    if (s == 0) begin : g_load
      // upper numerator bits are already below den
      assign rem_i = DEN_W'(num >> Q_W);
      assign low_i = num[Q_W-1:0];
      assign quo_i = '0;
      assign den_i = den;
    end else begin : g_chain
      assign rem_i = rem_p[s];
      assign low_i = low_p[s];
      assign quo_i = quo_p[s];
      assign den_i = den_p[s];
    end

    always_comb begin
      logic [DEN_W:0] part;
      part  = '0;
      rem_n = rem_i;
      low_n = low_i;
      quo_n = quo_i;
      for (int k = 0; k < BPS; k++) begin
        if (s * BPS + k < Q_W) begin
          part  = {rem_n, low_n[Q_W-1]};
          low_n = low_n << 1;
          if (part >= {1'b0, den_i}) begin
            part  = part - {1'b0, den_i};
            quo_n = {quo_n[Q_W-2:0], 1'b1};
          end else begin
            quo_n = {quo_n[Q_W-2:0], 1'b0};
          end
          rem_n = part[DEN_W-1:0];
        end
      end
    end

    always_ff @(posedge clk) begin
      rem_p[s+1] <= rem_n;
      low_p[s+1] <= low_n;
      quo_p[s+1] <= quo_n;
      den_p[s+1] <= den_i;
    end
  end

  assign quo = quo_p[STAGES];

endmodule

FILE: sv/hsv_rgb_range_color_key_unit.sv
// Top level of the HSV/RGB color key: config registers, front end, dividers, key compare.
// Depends on hrck_pkg, hrck_regs, hrck_prep and hrck_div.
//
// Usage:
//   A pixel transaction is taken at each rising edge where start is high and
//   busy is low. busy is low at all times outside reset, so a pixel may be
//   sent every cycle.
//   Each pixel produces one result, shown on res for exactly one cycle with
//   res_valid high; on the way it passes 2 front-end stages, 4 divider stages
//   and 1 compare/output stage.
//   Results leave in input order.
//   Hue and saturation come from two 4-stage restoring dividers running side
//   by side, at most 4 quotient bits per stage; they make up most of the pipeline.
//   Throughput is one pixel per clock.
//   The receiver has no way to hold results off; res_valid is a strobe.
//   Thresholds are set over the APB port (register i at byte 4*i), pready is
//   always high. Change them only while no pixel is in flight.
//   Synchronous reset clears the pipeline valid bits and loads the
//   pass-everything thresholds; pixels are not taken while rst is high.
module hsv_rgb_range_color_key_unit (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  hrck_pkg::pix_t              pix,
  output logic                        res_valid,
  output hrck_pkg::res_t              res,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [hrck_pkg::ADDR_W-1:0] paddr,
  input  logic [hrck_pkg::DATA_W-1:0] pwdata,
  output logic [hrck_pkg::DATA_W-1:0] prdata,
  output logic                        pready
);

  hrck_pkg::cfg_t  cfg;
  hrck_pkg::prep_t prep;

  logic [hrck_pkg::HUE_W-1:0] hue_q;
  logic [hrck_pkg::SAT_W-1:0] sat_q;

  logic                       vld  [hrck_pkg::DIV_STAGES];
  hrck_pkg::pix_t             dpix [hrck_pkg::DIV_STAGES];
  logic [hrck_pkg::PIX_W-1:0] dmx  [hrck_pkg::DIV_STAGES];

  hrck_pkg::pix_t             px;
  logic [hrck_pkg::PIX_W-1:0] mx;
  logic                       hsv_ok;
  logic                       rgb_ok;
  logic                       red_ok;
  logic                       grn_ok;
  logic                       blu_ok;

  assign busy = rst;

  hrck_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  hrck_prep u_prep (
    .clk      (clk),
    .rst      (rst),
    .in_valid (start && !busy),
    .pix      (pix),
    .prep     (prep)
  );

  hrck_div #(
    .NUM_W  (hrck_pkg::HUE_NUM_W),
    .DEN_W  (hrck_pkg::PIX_W),
    .Q_W    (hrck_pkg::HUE_W),
    .STAGES (hrck_pkg::DIV_STAGES)
  ) u_div_hue (
    .clk (clk),
    .num (prep.num_hue),
    .den (prep.den_hue),
    .quo (hue_q)
  );

  hrck_div #(
    .NUM_W  (hrck_pkg::SAT_NUM_W),
    .DEN_W  (hrck_pkg::PIX_W),
    .Q_W    (hrck_pkg::SAT_W),
    .STAGES (hrck_pkg::DIV_STAGES)
  ) u_div_sat (
    .clk (clk),
    .num (prep.num_sat),
    .den (prep.den_sat),
    .quo (sat_q)
  );

  // sideband follows the dividers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < hrck_pkg::DIV_STAGES; i++) vld[i] <= 1'b0;
    end else begin
      vld[0] <= prep.valid;
      for (int i = 1; i < hrck_pkg::DIV_STAGES; i++) vld[i] <= vld[i-1];
    end
    dpix[0] <= prep.pix;
    dmx[0]  <= prep.mx;
    for (int i = 1; i < hrck_pkg::DIV_STAGES; i++) begin
      dpix[i] <= dpix[i-1];
      dmx[i]  <= dmx[i-1];
    end
  end

  assign px = dpix[hrck_pkg::DIV_STAGES-1];
  assign mx = dmx[hrck_pkg::DIV_STAGES-1];

  assign hsv_ok = (hue_q >= cfg.hue_low) && (hue_q <= cfg.hue_high) &&
                  (sat_q >= cfg.sat_low) && (sat_q <= cfg.sat_high) &&
                  (mx >= cfg.val_low) && (mx <= cfg.val_high);

  assign red_ok = (px.pix_red >= cfg.chan_low[7:0]) &&
                  (px.pix_red <= cfg.chan_high[7:0]);
  assign grn_ok = (px.pix_green >= cfg.chan_low[15:8]) &&
                  (px.pix_green <= cfg.chan_high[15:8]);
  assign blu_ok = (px.pix_blue >= cfg.chan_low[23:16]) &&
                  (px.pix_blue <= cfg.chan_high[23:16]);
  assign rgb_ok = red_ok && grn_ok && blu_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else begin
      res_valid <= vld[hrck_pkg::DIV_STAGES-1];
    end
    res.hsv_out_red   <= hsv_ok ? px.pix_red : '0;
    res.hsv_out_green <= hsv_ok ? px.pix_green : '0;
    res.hsv_out_blue  <= hsv_ok ? px.pix_blue : '0;
    res.rgb_out_red   <= rgb_ok ? px.pix_red : '0;
    res.rgb_out_green <= rgb_ok ? px.pix_green : '0;
    res.rgb_out_blue  <= rgb_ok ? px.pix_blue : '0;
    res.hue_val       <= hue_q;
    res.sat_val       <= sat_q;
    res.bright_val    <= mx;
    res.hsv_hit       <= hsv_ok;
    res.rgb_hit       <= rgb_ok;
  end

`ifndef NO_ASSERTIONS
  a_res_has_source: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> $past(start && !busy, hrck_pkg::LATENCY))
    else $error("result strobe without a matching pixel transaction");

  a_quo_range: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (res.hue_val < hrck_pkg::HUE_LIMIT) && (res.sat_val <= hrck_pkg::SAT_MAX))
    else $error("hue or saturation out of range");

  a_black_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && (res.bright_val == '0) |-> (res.hue_val == '0) && (res.sat_val == '0))
    else $error("black pixel gave nonzero hue or saturation");
`endif

endmodule
